// ===== sv/mlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the magic/length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

	localparam int unsigned HDR_BYTES   = 8;
	localparam int unsigned FIFO_DEPTH  = 8;
	localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	// room for the result of the stage in flight plus the one entering it
	localparam int unsigned FIFO_ACCEPT_MAX = FIFO_DEPTH - 4;

	localparam logic [31:0] LEN_SKIP = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
	} res_t;

	typedef struct packed {
		logic s1_valid;
		logic in_payload;
	} parse_stat_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  space_ok;
	} fifo_stat_t;

endpackage

// ===== sv/mlfd_parser.sv =====
// ----------------------------------------------------------------------------
// mlfd_parser
// Input register and frame state: collects the header, checks magic and
// length, and emits up to two results per byte.
// ----------------------------------------------------------------------------
module mlfd_parser
	import mlfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_accept,
	input  logic [7:0]  byte_in,
	input  logic [31:0] magic_q,
	output logic        wr0,
	output res_t        res0,
	output logic        wr1,
	output res_t        res1,
	output parse_stat_t stat
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        in_payload_q, in_payload_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [55:0] hdr_shift_q, hdr_shift_d;
	logic [31:0] bytes_left_q, bytes_left_d;

	logic [31:0] hdr_magic;
	logic [31:0] hdr_len;
	logic        mismatch;
	logic        last_byte;

	assign hdr_magic = hdr_shift_q[55:24];
	assign hdr_len   = {hdr_shift_q[23:0], byte_s1};
	assign mismatch  = (hdr_magic != magic_q);
	assign last_byte = (bytes_left_q <= 32'd1);

	always_comb begin
		in_payload_d = in_payload_q;
		hdr_cnt_d    = hdr_cnt_q;
		hdr_shift_d  = hdr_shift_q;
		bytes_left_d = bytes_left_q;
		wr0          = 1'b0;
		wr1          = 1'b0;
		res0         = '{kind: KIND_DATA, data: 8'd0, last: 1'b0};
		res1         = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
		if (valid_s1) begin
			if (in_payload_q) begin
				wr0  = 1'b1;
				res0 = '{kind: KIND_DATA, data: byte_s1, last: last_byte};
				if (last_byte) begin
					bytes_left_d = 32'd0;
					in_payload_d = 1'b0;
					hdr_cnt_d    = 3'd0;
					hdr_shift_d  = 56'd0;
				end else begin
					bytes_left_d = bytes_left_q - 32'd1;
				end
			end else if (hdr_cnt_q != 3'(HDR_BYTES - 1)) begin
				hdr_shift_d = {hdr_shift_q[47:0], byte_s1};
				hdr_cnt_d   = hdr_cnt_q + 3'd1;
			end else begin
				hdr_cnt_d   = 3'd0;
				hdr_shift_d = 56'd0;
				// error goes first; an empty message then takes the second slot
				if (mismatch) begin
					wr0  = 1'b1;
					res0 = '{kind: KIND_ERROR, data: 8'd0, last: 1'b0};
					wr1  = (hdr_len == 32'd0);
				end else if (hdr_len == 32'd0) begin
					wr0  = 1'b1;
					res0 = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
				end
				if (hdr_len != 32'd0 && hdr_len != LEN_SKIP) begin
					in_payload_d = 1'b1;
					bytes_left_d = hdr_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= 3'd0;
			hdr_shift_q  <= 56'd0;
			bytes_left_q <= 32'd0;
		end else begin
			valid_s1     <= in_accept;
			in_payload_q <= in_payload_d;
			hdr_cnt_q    <= hdr_cnt_d;
			hdr_shift_q  <= hdr_shift_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= byte_in;
		end
	end

	assign stat = '{s1_valid: valid_s1, in_payload: in_payload_q};

endmodule

// ===== sv/mlfd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mlfd_out_fifo
// Result queue: takes up to two results per cycle, hands out one per
// transfer.
// ----------------------------------------------------------------------------
module mlfd_out_fifo
	import mlfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr0,
	input  res_t       res0,
	input  logic       wr1,
	input  res_t       res1,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       res_out,
	output fifo_stat_t stat
);

	res_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [FIFO_PTR_W-1:0] wptr_nx;
	logic                  pop;
	logic [1:0]            n_push;

	assign wptr_nx   = wptr_q + FIFO_PTR_W'(1);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign n_push    = {1'b0, wr0} + {1'b0, wr1};
	assign res_out   = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem[wptr_q] <= res0;
		end
		if (wr1) begin
			mem[wptr_nx] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_PTR_W'(n_push);
			if (pop) begin
				rptr_q <= rptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
		end
	end

	assign stat = '{count: count_q, space_ok: (count_q <= FIFO_CNT_W'(FIFO_ACCEPT_MAX))};

endmodule

// ===== sv/magic_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Splits a byte stream of magic/length framed messages into payload bytes,
// empty-message marks and magic mismatch errors.
// ----------------------------------------------------------------------------
// A result passes through the input register and the result queue before it
// is offered. Throughput: one byte per cycle while the queue has room; the
// input register feeds a single pass of header/payload logic that writes an
// eight-entry result queue.
// Input ready drops only while that queue holds more than four results.
// Reset: asynchronous, active low; frame state and queue clear, the stored magic
// returns to zero, and the block expects a header.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer
	import mlfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        last_of_message,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] magic_word
);

	logic [31:0] magic_q;
	logic        in_accept;
	logic        wr0, wr1;
	res_t        res0, res1, res_out;
	parse_stat_t pstat;
	fifo_stat_t  fstat;

	assign cfg_ready = 1'b1;
	assign in_ready  = fstat.space_ok;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			magic_q <= magic_word;
		end
	end

	mlfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.byte_in   (byte_in),
		.magic_q   (magic_q),
		.wr0       (wr0),
		.res0      (res0),
		.wr1       (wr1),
		.res1      (res1),
		.stat      (pstat)
	);

	mlfd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr0       (wr0),
		.res0      (res0),
		.wr1       (wr1),
		.res1      (res1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out),
		.stat      (fstat)
	);

	assign kind            = res_out.kind;
	assign data_byte       = res_out.data;
	assign last_of_message = res_out.last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_s1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> pstat.s1_valid)
		else $error("accepted byte missing from input stage");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pstat.s1_valid |-> !wr0 && !wr1)
		else $error("result written with no byte in flight");

	a_marks_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
		else $error("non-payload result carries data");

endmodule

// ===== tb/tb_magic_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_magic_length_frame_deframer
// Drives framed byte streams into the deframer and checks every result
// against a cycle-free software deframer kept alongside the stimulus. The
// run covers the header corner cases, magic_word changes (at the extremes
// and between header bytes), a long stretch of random frames under varying
// input gaps and output stalls, and finally a frame whose length cannot
// complete.
// ----------------------------------------------------------------------------
module tb_magic_length_frame_deframer;
	import mlfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        last_of_message;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] magic_word;

	// software deframer state
	logic [31:0] cur_magic;
	logic        in_body;
	int unsigned hdr_count;
	logic [55:0] hdr_bytes;
	logic [31:0] body_left;
	res_t        due_results[$];

	// pacing
	int unsigned max_gap;
	int unsigned max_burst;
	int unsigned burst_left;
	logic [15:0] stall_pat;
	logic [3:0]  stall_pos;

	int unsigned bytes_sent;
	int unsigned frames_sent;
	int unsigned cfg_writes;
	int unsigned n_data;
	int unsigned n_empty;
	int unsigned n_error;
	int unsigned fail_count;

	magic_length_frame_deframer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.byte_in         (byte_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.data_byte       (data_byte),
		.last_of_message (last_of_message),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.magic_word      (magic_word)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= stall_pat[stall_pos];
		stall_pos <= stall_pos + 4'd1;
	end

	function automatic res_t make_res(input kind_t k, input logic [7:0] d, input logic l);
		res_t r;
		r.kind = k;
		r.data = d;
		r.last = l;
		return r;
	endfunction

	// Advance the software deframer by one accepted byte.
	task automatic deframe_byte(input logic [7:0] b);
		logic [63:0] hdr;
		if (in_body) begin
			due_results.push_back(make_res(KIND_DATA, b, body_left <= 32'd1));
			if (body_left <= 32'd1) begin
				in_body = 1'b0;
				body_left = '0;
				hdr_count = 0;
				hdr_bytes = '0;
			end else begin
				body_left = body_left - 32'd1;
			end
		end else if (hdr_count < HDR_BYTES - 1) begin
			hdr_bytes = {hdr_bytes[47:0], b};
			hdr_count++;
		end else begin
			hdr = {hdr_bytes, b};
			hdr_count = 0;
			hdr_bytes = '0;
			if (hdr[63:32] != cur_magic)
				due_results.push_back(make_res(KIND_ERROR, 8'h00, 1'b0));
			if (hdr[31:0] == 32'd0) begin
				due_results.push_back(make_res(KIND_EMPTY, 8'h00, 1'b1));
			end else if (hdr[31:0] != LEN_SKIP) begin
				in_body = 1'b1;
				body_left = hdr[31:0];
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (max_gap != 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, max_gap)) @(negedge clk);
			burst_left = $urandom_range(1, max_burst);
		end
		if (burst_left != 0)
			burst_left--;
		in_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [31:0] m, input logic [31:0] len);
		logic [63:0] hdr;
		hdr = {m, len};
		for (int i = 7; i >= 0; i--)
			send_byte(hdr[i*8 +: 8]);
		frames_sent++;
	endtask

	// mimic: open the payload with the current magic bytes
	task automatic send_payload(input int unsigned n, input logic mimic);
		for (int unsigned i = 0; i < n; i++) begin
			if (mimic && i < 4)
				send_byte(cur_magic[(3 - i)*8 +: 8]);
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Drop input valid and drain every outstanding result.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_magic(input logic [31:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		magic_word <= value;
		do @(posedge clk); while (!cfg_ready);
		cur_magic = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_pacing();
		case ($urandom_range(0, 4))
			0: begin
				max_gap = 0;
				stall_pat = 16'hFFFF;
			end
			1: begin
				max_gap = 3;
				max_burst = 12;
				stall_pat = 16'($urandom()) | 16'h0001;
			end
			2: begin
				max_gap = 8;
				max_burst = 3;
				stall_pat = 16'hFFFF;
			end
			3: begin
				// heavy back-pressure fills the result queue
				max_gap = 0;
				stall_pat = 16'h0101;
			end
			default: begin
				max_gap = 2;
				max_burst = 30;
				stall_pat = 16'($urandom()) | 16'h8000;
			end
		endcase
		burst_left = 0;
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind_t'(kind);
			got.data = data_byte;
			got.last = last_of_message;
			case (got.kind)
				KIND_DATA:  n_data++;
				KIND_EMPTY: n_empty++;
				default:    n_error++;
			endcase
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result kind=%0d data=%02h last=%0b",
						$realtime, kind, data_byte, last_of_message);
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: mismatch kind %0d/%0d data %02h/%02h last %0b/%0b (exp/got)",
							$realtime, want.kind, kind, want.data, data_byte,
							want.last, last_of_message);
				end
			end
		end
	end

	task automatic test_header_cases();
		max_gap = 0;
		stall_pat = 16'hFFFF;
		// magic resets to zero: matching empty message
		send_header(32'h0000_0000, 32'd0);
		// mismatch with a one-byte payload
		send_header(32'hFFFF_FFFF, 32'd1);
		send_payload(1, 1'b0);
		// skip length with a mismatch: error only
		send_header(32'h8000_0001, LEN_SKIP);
	endtask

	task automatic test_magic_setting();
		logic [31:0] m;
		logic [63:0] hdr;
		write_magic(32'hFFFF_FFFF);
		send_header(32'hFFFF_FFFF, LEN_SKIP);
		send_header(32'hFFFF_FFFF, 32'd2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(32'h0000_0000, 32'd0);
		// change magic halfway through a header
		m = $urandom();
		hdr = {m, 32'd3};
		for (int i = 7; i >= 4; i--)
			send_byte(hdr[i*8 +: 8]);
		write_magic(m);
		for (int i = 3; i >= 0; i--)
			send_byte(hdr[i*8 +: 8]);
		frames_sent++;
		send_payload(3, 1'b0);
	endtask

	task automatic test_random_frames();
		int unsigned start;
		int unsigned nframe;
		int unsigned roll;
		logic [31:0] m;
		logic [31:0] len;
		start = bytes_sent;
		nframe = 0;
		while (bytes_sent - start < 450) begin
			if (nframe % 12 == 11) begin
				case ($urandom_range(0, 3))
					0:       write_magic(32'h0000_0000);
					1:       write_magic(32'hFFFF_FFFF);
					default: write_magic($urandom());
				endcase
			end
			if (nframe % 7 == 0)
				pick_pacing();
			roll = $urandom_range(0, 99);
			if (roll < 80)
				m = cur_magic;
			else if (roll < 90)
				m = cur_magic ^ (32'h1 << $urandom_range(0, 31));
			else
				m = $urandom();
			roll = $urandom_range(0, 99);
			if (roll < 10)
				len = 32'd0;
			else if (roll < 18)
				len = LEN_SKIP;
			else if (roll < 88)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(13, 48);
			send_header(m, len);
			if (len != LEN_SKIP)
				send_payload(len, $urandom_range(0, 9) == 0);
			nframe++;
		end
	endtask

	// A length this large never completes; run it last.
	task automatic test_open_length();
		logic [31:0] len;
		pick_pacing();
		len = 32'h8000_0000 | $urandom();
		if (len == LEN_SKIP)
			len = 32'hFFFF_FFFE;
		send_header($urandom(), len);
		send_payload(40, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		magic_word = 32'h0;
		cur_magic = 32'h0;
		in_body = 1'b0;
		hdr_count = 0;
		hdr_bytes = '0;
		body_left = '0;
		max_gap = 0;
		max_burst = 1;
		burst_left = 0;
		stall_pat = 16'hFFFF;
		stall_pos = 4'd0;
		bytes_sent = 0;
		frames_sent = 0;
		cfg_writes = 0;
		n_data = 0;
		n_empty = 0;
		n_error = 0;
		fail_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_header_cases();
		test_magic_setting();
		test_random_frames();
		test_open_length();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d frames with %0d magic_word writes.",
			bytes_sent, frames_sent, cfg_writes);
		$display("Checked %0d payload bytes, %0d empty messages, %0d magic errors.",
			n_data, n_empty, n_error);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d failures", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", due_results.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
